[rtl/dle_pkg.sv]
// ----------------------------------------------------------------------------
// dle_pkg
// shared types and constants of the dns label encoder
// ----------------------------------------------------------------------------
package dle_pkg;

    localparam int BUFFER_DEPTH = 512;
    localparam int MAX_LABEL    = 63;

    localparam int CHAR_W = 8;
    localparam int ADDR_W = 9;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 7;
    localparam int CFG_W  = 10;

    localparam logic [CHAR_W-1:0] DOT_CHAR = 8'd46;
    localparam logic [POS_W-1:0]  LIM_MIN  = POS_W'(2);
    localparam logic [POS_W-1:0]  LIM_MAX  = POS_W'(BUFFER_DEPTH);

    // result queue, two free slots are needed to take a transaction
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LABEL = 2'd1,
        ST_TRUNC = 2'd2
    } status_t;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [CHAR_W-1:0] write_byte;
        logic              is_last;
        status_t           status;
        logic [POS_W-1:0]  encoded_length;
    } result_t;

    // up to two results produced by one accepted transaction
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

[rtl/dle_in_if.sv]
// ----------------------------------------------------------------------------
// dle_in_if
// name character channel
// ----------------------------------------------------------------------------
interface dle_in_if;
    logic                        valid;
    logic                        ready;
    logic [dle_pkg::CHAR_W-1:0]  character;
    logic                        end_of_name;

    modport source (output valid, output character, output end_of_name, input ready);
    modport sink   (input valid, input character, input end_of_name, output ready);
endinterface

[rtl/dle_out_if.sv]
// ----------------------------------------------------------------------------
// dle_out_if
// buffer write result channel
// ----------------------------------------------------------------------------
interface dle_out_if;
    logic                        valid;
    logic                        ready;
    logic                        write_valid;
    logic [dle_pkg::ADDR_W-1:0]  write_address;
    logic [dle_pkg::CHAR_W-1:0]  write_byte;
    logic                        is_last;
    logic [1:0]                  status;
    logic [dle_pkg::POS_W-1:0]   encoded_length;

    modport source (output valid, output write_valid, output write_address,
                    output write_byte, output is_last, output status,
                    output encoded_length, input ready);
    modport sink   (input valid, input write_valid, input write_address,
                    input write_byte, input is_last, input status,
                    input encoded_length, output ready);
endinterface

[rtl/dle_core.sv]
// ----------------------------------------------------------------------------
// dle_core
// label state tracking and result generation for one accepted character per cycle
// ----------------------------------------------------------------------------
module dle_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dle_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         accept,
    input  logic [dle_pkg::CHAR_W-1:0]   character,
    input  logic                         end_of_name,
    output dle_pkg::push_t               push
);

    logic [dle_pkg::POS_W-1:0]  lim_reg;
    logic [dle_pkg::POS_W-1:0]  next_position_reg, next_position_next;
    logic [dle_pkg::ADDR_W-1:0] length_slot_reg, length_slot_next;
    logic [dle_pkg::CNT_W-1:0]  label_count_reg, label_count_next;
    logic                       label_open_reg, label_open_next;
    dle_pkg::status_t           error_status_reg, error_status_next;

    // clamped buffer size kept ready for use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= dle_pkg::LIM_MAX;
        end
        else if (cfg_we)
        begin
            if (cfg_wdata < dle_pkg::LIM_MIN)
            begin
                lim_reg <= dle_pkg::LIM_MIN;
            end
            else if (cfg_wdata > dle_pkg::LIM_MAX)
            begin
                lim_reg <= dle_pkg::LIM_MAX;
            end
            else
            begin
                lim_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        logic                      close_emit;
        logic                      close_trunc;
        logic [dle_pkg::POS_W-1:0] slot_ext;
        logic [dle_pkg::POS_W-1:0] label_len;
        logic [dle_pkg::POS_W-1:0] np1;
        logic [dle_pkg::CNT_W-1:0] cnt1;
        dle_pkg::status_t          err_close;

        next_position_next = next_position_reg;
        length_slot_next   = length_slot_reg;
        label_count_next   = label_count_reg;
        label_open_next    = label_open_reg;
        error_status_next  = error_status_reg;
        push               = '0;

        slot_ext    = {1'b0, length_slot_reg};
        label_len   = next_position_reg - slot_ext - dle_pkg::POS_W'(1);
        close_emit  = label_open_reg && (slot_ext < next_position_reg)
                      && ((slot_ext + dle_pkg::POS_W'(1)) < lim_reg);
        close_trunc = label_open_reg && !close_emit;
        err_close   = close_trunc ? dle_pkg::ST_TRUNC : error_status_reg;

        np1  = next_position_reg;
        cnt1 = '0;

        // length byte of the label being closed
        push.res0.write_valid    = 1'b1;
        push.res0.write_address  = length_slot_reg;
        push.res0.write_byte     = label_len[dle_pkg::CHAR_W-1:0];
        push.res0.is_last        = 1'b0;
        push.res0.status         = dle_pkg::ST_OK;
        push.res0.encoded_length = '0;

        if (accept)
        begin
            if (end_of_name)
            begin
                push.res1.is_last = 1'b1;
                if (error_status_reg == dle_pkg::ST_LABEL)
                begin
                    push.push0      = 1'b1;
                    push.res0       = '0;
                    push.res0.is_last = 1'b1;
                    push.res0.status  = dle_pkg::ST_LABEL;
                end
                else
                begin
                    // terminator goes to res1 when a length byte precedes it
                    push.push0 = 1'b1;
                    push.push1 = close_emit;
                    if (next_position_reg < lim_reg)
                    begin
                        push.res1.write_valid    = 1'b1;
                        push.res1.write_address  = next_position_reg[dle_pkg::ADDR_W-1:0];
                        push.res1.status         = err_close;
                        push.res1.encoded_length = next_position_reg + dle_pkg::POS_W'(1);
                    end
                    else
                    begin
                        push.res1.status         = dle_pkg::ST_TRUNC;
                        push.res1.encoded_length = next_position_reg;
                    end
                    if (!close_emit)
                    begin
                        push.res0 = push.res1;
                    end
                end
                next_position_next = '0;
                length_slot_next   = '0;
                label_count_next   = '0;
                label_open_next    = 1'b0;
                error_status_next  = dle_pkg::ST_OK;
            end
            else if (error_status_reg != dle_pkg::ST_LABEL)
            begin
                if (character == dle_pkg::DOT_CHAR)
                begin
                    push.push0        = close_emit;
                    label_open_next   = 1'b0;
                    error_status_next = err_close;
                end
                else
                begin
                    if (!label_open_reg)
                    begin
                        length_slot_next = next_position_reg[dle_pkg::ADDR_W-1:0];
                        if ((next_position_reg + dle_pkg::POS_W'(1)) < lim_reg)
                        begin
                            np1 = next_position_reg + dle_pkg::POS_W'(1);
                        end
                        else
                        begin
                            error_status_next = dle_pkg::ST_TRUNC;
                        end
                        cnt1 = dle_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        cnt1 = label_count_reg + dle_pkg::CNT_W'(1);
                    end
                    label_open_next    = 1'b1;
                    label_count_next   = cnt1;
                    next_position_next = np1;
                    if (cnt1 > dle_pkg::CNT_W'(dle_pkg::MAX_LABEL))
                    begin
                        error_status_next = dle_pkg::ST_LABEL;
                    end
                    else if ((np1 + dle_pkg::POS_W'(1)) < lim_reg)
                    begin
                        push.push0               = 1'b1;
                        push.res0.write_address  = np1[dle_pkg::ADDR_W-1:0];
                        push.res0.write_byte     = character;
                        next_position_next       = np1 + dle_pkg::POS_W'(1);
                    end
                    else
                    begin
                        error_status_next = dle_pkg::ST_TRUNC;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_position_reg <= '0;
            length_slot_reg   <= '0;
            label_count_reg   <= '0;
            label_open_reg    <= 1'b0;
            error_status_reg  <= dle_pkg::ST_OK;
        end
        else
        begin
            next_position_reg <= next_position_next;
            length_slot_reg   <= length_slot_next;
            label_count_reg   <= label_count_next;
            label_open_reg    <= label_open_next;
            error_status_reg  <= error_status_next;
        end
    end

endmodule

[rtl/dle_out_fifo.sv]
// ----------------------------------------------------------------------------
// dle_out_fifo
// small result queue taking up to two results per cycle, giving one per cycle when popped
// ----------------------------------------------------------------------------
module dle_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dle_pkg::push_t        push,
    output logic                  space_ok,
    output logic                  head_valid,
    output dle_pkg::result_t      head,
    input  logic                  pop
);

    dle_pkg::result_t               entry_reg [dle_pkg::QDEPTH];
    logic [dle_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dle_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dle_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic [dle_pkg::QPTR_W-1:0]     wr_ptr_p1;
    logic [dle_pkg::QCNT_W-1:0]     n_push;
    logic                           do_pop;

    assign wr_ptr_p1  = wr_ptr_reg + dle_pkg::QPTR_W'(1);
    assign n_push     = dle_pkg::QCNT_W'(push.push0) + dle_pkg::QCNT_W'(push.push1);
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = entry_reg[rd_ptr_reg];
    assign space_ok   = (count_reg <= dle_pkg::QCNT_W'(dle_pkg::QDEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + n_push[dle_pkg::QPTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + dle_pkg::QPTR_W'(do_pop);
    assign count_next  = count_reg + n_push - dle_pkg::QCNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            entry_reg[wr_ptr_p1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/dns_label_encoder_unit.sv]
// ----------------------------------------------------------------------------
// dns_label_encoder_unit
// dotted name to dns wire label form, emitted as buffer writes
// ----------------------------------------------------------------------------
//  channel   dir   payload                                     transaction
//  in_ch     in    character, end_of_name                      valid & ready
//  out_ch    out   write_valid, write_address, write_byte,     valid & ready
//                  is_last, status, encoded_length
//  cfg       in    cfg_wdata (buffer_size)                     cfg_we
//
//  one input transaction per cycle while in_ch.ready is high; its results
//  are registered in a four-entry result queue and then appear on out_ch
//  an end of name can yield two results, drained one per cycle while out_ch.ready is high
//  in_ch.ready is high while the queue has at least two free entries
//  reset clears the label state, the queue and sets buffer_size to 512
// ----------------------------------------------------------------------------
module dns_label_encoder_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dle_pkg::CFG_W-1:0]  cfg_wdata,
    dle_in_if.sink                     in_ch,
    dle_out_if.source                  out_ch
);

    dle_pkg::push_t   push;
    dle_pkg::result_t head;
    logic             space_ok;
    logic             head_valid;
    logic             accept;

    assign in_ch.ready = space_ok;
    assign accept      = in_ch.valid && space_ok;

    dle_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .character   (in_ch.character),
        .end_of_name (in_ch.end_of_name),
        .push        (push)
    );

    dle_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head       (head),
        .pop        (out_ch.ready)
    );

    assign out_ch.valid          = head_valid;
    assign out_ch.write_valid    = head.write_valid;
    assign out_ch.write_address  = head.write_address;
    assign out_ch.write_byte     = head.write_byte;
    assign out_ch.is_last        = head.is_last;
    assign out_ch.status         = head.status;
    assign out_ch.encoded_length = head.encoded_length;

endmodule
